>>> sv/qbpc_pkg.sv
// Shared types, widths and arithmetic helpers for the quadric best-point cost block.
package qbpc_pkg;

  localparam int CW      = 32;           // coefficient and point width
  localparam int KW      = 64;           // adjugate entry width
  localparam int TW      = 100;          // wide signed sum width
  localparam int AW      = TW - 1;       // magnitude width of determinant and numerators
  localparam int EW      = 48;           // cost width
  localparam int QBITS   = 32;           // quotient bits resolved by the divider
  localparam int FRONT_LAT = 6;
  localparam int DIV_LAT   = QBITS + 3;
  localparam int COST_LAT  = 5;
  localparam int LATENCY   = FRONT_LAT + DIV_LAT + COST_LAT;

  localparam logic [CW-1:0] THR_RESET = CW'(1);
  localparam logic signed [EW-1:0] COST_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] COST_MIN = {1'b1, {(EW-1){1'b0}}};
  localparam logic signed [CW-1:0] PT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] PT_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] q_xx;
    logic signed [CW-1:0] q_xy;
    logic signed [CW-1:0] q_xz;
    logic signed [CW-1:0] q_xw;
    logic signed [CW-1:0] q_yy;
    logic signed [CW-1:0] q_yz;
    logic signed [CW-1:0] q_yw;
    logic signed [CW-1:0] q_zz;
    logic signed [CW-1:0] q_zw;
    logic signed [CW-1:0] q_ww;
  } qbpc_in_t;

  typedef struct packed {
    logic                 solvable;
    logic signed [CW-1:0] best_x;
    logic signed [CW-1:0] best_y;
    logic signed [CW-1:0] best_z;
    logic signed [EW-1:0] err_cost;
  } qbpc_out_t;

  // Front end result handed to the three dividers.
  typedef struct packed {
    logic                    solvable;
    logic [AW-1:0]           det_mag;
    logic [2:0][AW-1:0]      num_mag;
    logic [2:0]              neg;
  } qbpc_sol_t;

  // Upper partial product of a 64 by 32 signed multiply.
  function automatic logic signed [63:0] pp_hi(input logic signed [KW-1:0] a,
                                               input logic signed [CW-1:0] b);
    logic signed [CW-1:0] ah;
    ah = a[KW-1:CW];
    pp_hi = ah * b;
  endfunction

  // Lower partial product; the low half of a is taken as unsigned.
  function automatic logic signed [64:0] pp_lo(input logic signed [KW-1:0] a,
                                               input logic signed [CW-1:0] b);
    logic signed [CW:0] al;
    al = {1'b0, a[CW-1:0]};
    pp_lo = al * b;
  endfunction

  function automatic logic signed [TW-1:0] pp_join(input logic signed [63:0] hi,
                                                   input logic signed [64:0] lo);
    logic signed [TW-1:0] h;
    logic signed [TW-1:0] l;
    h = {{(TW-64){hi[63]}}, hi};
    l = {{(TW-65){lo[64]}}, lo};
    pp_join = (h <<< CW) + l;
  endfunction

endpackage

>>> sv/qbpc_front.sv
// Adjugate, determinant, numerators and solvability test, six register stages.
module qbpc_front import qbpc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  qbpc_in_t        in_data,
  input  logic [CW-1:0]   thr,
  output logic            out_valid,
  output qbpc_in_t        out_item,
  output qbpc_sol_t       out_sol
);

  logic [5:0] v_r;
  qbpc_in_t   it1_r, it2_r, it3_r, it4_r, it5_r, it6_r;

  logic signed [KW-1:0] p_nxt [12];
  logic signed [KW-1:0] p_r   [12];
  logic signed [KW-1:0] k_nxt [6];
  logic signed [KW-1:0] k_r   [6];
  logic signed [KW-1:0] ka    [12];
  logic signed [CW-1:0] ca    [12];
  logic signed [63:0]   hi_r  [12];
  logic signed [64:0]   lo_r  [12];
  logic signed [TW-1:0] t_r   [12];
  logic signed [TW-1:0] s_r   [4];
  qbpc_sol_t            sol_nxt, sol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_comb begin
    p_nxt[0]  = in_data.q_yy * in_data.q_zz;
    p_nxt[1]  = in_data.q_yz * in_data.q_yz;
    p_nxt[2]  = in_data.q_yz * in_data.q_xz;
    p_nxt[3]  = in_data.q_xy * in_data.q_zz;
    p_nxt[4]  = in_data.q_xy * in_data.q_yz;
    p_nxt[5]  = in_data.q_xz * in_data.q_yy;
    p_nxt[6]  = in_data.q_zz * in_data.q_xx;
    p_nxt[7]  = in_data.q_xz * in_data.q_xz;
    p_nxt[8]  = in_data.q_xz * in_data.q_xy;
    p_nxt[9]  = in_data.q_xx * in_data.q_yz;
    p_nxt[10] = in_data.q_xx * in_data.q_yy;
    p_nxt[11] = in_data.q_xy * in_data.q_xy;
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      k_nxt[i] = p_r[2*i] - p_r[2*i+1];
    end
  end

  // Product table: determinant row, then the x, y and z numerators.
  always_comb begin
    ka[0]  = k_r[0]; ca[0]  = it2_r.q_xx;
    ka[1]  = k_r[1]; ca[1]  = it2_r.q_xy;
    ka[2]  = k_r[2]; ca[2]  = it2_r.q_xz;
    ka[3]  = k_r[0]; ca[3]  = it2_r.q_xw;
    ka[4]  = k_r[1]; ca[4]  = it2_r.q_yw;
    ka[5]  = k_r[2]; ca[5]  = it2_r.q_zw;
    ka[6]  = k_r[1]; ca[6]  = it2_r.q_xw;
    ka[7]  = k_r[3]; ca[7]  = it2_r.q_yw;
    ka[8]  = k_r[4]; ca[8]  = it2_r.q_zw;
    ka[9]  = k_r[2]; ca[9]  = it2_r.q_xw;
    ka[10] = k_r[4]; ca[10] = it2_r.q_yw;
    ka[11] = k_r[5]; ca[11] = it2_r.q_zw;
  end

  always_comb begin
    logic signed [TW-1:0] d;
    logic signed [TW-1:0] n;
    logic signed [TW-1:0] m;
    logic [AW-1:0]        lim;
    d = s_r[0];
    m = d[TW-1] ? -d : d;
    sol_nxt.det_mag = m[AW-1:0];
    lim = AW'({thr, {CW{1'b0}}});
    sol_nxt.solvable = (d != '0) && (sol_nxt.det_mag >= lim);
    for (int j = 0; j < 3; j++) begin
      n = s_r[j+1];
      m = n[TW-1] ? -n : n;
      sol_nxt.num_mag[j] = m[AW-1:0];
      sol_nxt.neg[j] = (n[TW-1] == d[TW-1]);
    end
  end

  always_ff @(posedge clk) begin
    it1_r <= in_data;
    it2_r <= it1_r;
    it3_r <= it2_r;
    it4_r <= it3_r;
    it5_r <= it4_r;
    it6_r <= it5_r;
    for (int i = 0; i < 12; i++) begin
      p_r[i]  <= p_nxt[i];
      hi_r[i] <= pp_hi(ka[i], ca[i]);
      lo_r[i] <= pp_lo(ka[i], ca[i]);
      t_r[i]  <= pp_join(hi_r[i], lo_r[i]);
    end
    for (int i = 0; i < 6; i++) begin
      k_r[i] <= k_nxt[i];
    end
    for (int j = 0; j < 4; j++) begin
      s_r[j] <= t_r[3*j] + t_r[3*j+1] + t_r[3*j+2];
    end
    sol_r <= sol_nxt;
  end

  assign out_valid = v_r[5];
  assign out_item  = it6_r;
  assign out_sol   = sol_r;

endmodule

>>> sv/qbpc_div.sv
// Pipelined restoring divider giving one rounded, saturated point coordinate.
module qbpc_div import qbpc_pkg::*; (
  input  logic                 clk,
  input  logic [AW-1:0]        num_mag,
  input  logic [AW-1:0]        det_mag,
  input  logic                 neg,
  output logic signed [CW-1:0] coord
);

  localparam int TOPW = AW + 18;
  localparam int DW   = AW + 1;
  localparam int RW   = DW + QBITS;

  logic [TOPW-1:0] top_r;
  logic [DW-1:0]   dv0_r;
  logic            neg0_r;

  logic [RW-1:0]    rem_r [QBITS+1];
  logic [DW-1:0]    dv_r  [QBITS+1];
  logic [QBITS-1:0] q_r   [QBITS+1];
  logic             sat_r [QBITS+1];
  logic             ng_r  [QBITS+1];
  logic signed [CW-1:0] coord_r;

  // Rounding to nearest: (2|n| + |d|) / (2|d|), scaled by 2^16.
  always_ff @(posedge clk) begin
    top_r  <= {1'b0, num_mag, 17'b0} + TOPW'(det_mag);
    dv0_r  <= {det_mag, 1'b0};
    neg0_r <= neg;
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= RW'(top_r);
    dv_r[0]  <= dv0_r;
    q_r[0]   <= '0;
    sat_r[0] <= RW'(top_r) >= {dv0_r, {QBITS{1'b0}}};
    ng_r[0]  <= neg0_r;
  end

  for (genvar g = 0; g < QBITS; g++) begin : g_bit
    localparam int B = QBITS - 1 - g;
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = RW'(dv_r[g]) << B;
    assign ge = rem_r[g] >= sh;
    always_ff @(posedge clk) begin
      rem_r[g+1] <= ge ? rem_r[g] - sh : rem_r[g];
      q_r[g+1]   <= q_r[g] | (QBITS'(ge) << B);
      dv_r[g+1]  <= dv_r[g];
      sat_r[g+1] <= sat_r[g];
      ng_r[g+1]  <= ng_r[g];
    end
  end

  always_ff @(posedge clk) begin
    logic [QBITS-1:0] q;
    q = q_r[QBITS];
    if (ng_r[QBITS]) begin
      if (sat_r[QBITS] || q > {1'b1, {(QBITS-1){1'b0}}}) begin
        coord_r <= PT_MIN;
      end else begin
        coord_r <= -$signed(CW'(q));
      end
    end else begin
      if (sat_r[QBITS] || q[QBITS-1]) begin
        coord_r <= PT_MAX;
      end else begin
        coord_r <= $signed(CW'(q));
      end
    end
  end

  assign coord = coord_r;

endmodule

>>> sv/qbpc_cost.sv
// Quadric cost evaluation at the solved point, five register stages.
module qbpc_cost import qbpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 solvable,
  input  qbpc_in_t             item,
  input  logic signed [CW-1:0] px,
  input  logic signed [CW-1:0] py,
  input  logic signed [CW-1:0] pz,
  output logic                 out_valid,
  output qbpc_out_t            out_data
);

  localparam logic signed [TW-1:0] RND = TW'(64'h8000_0000);

  logic [4:0]           v_r;
  logic [3:0]           sv_r;
  logic signed [CW-1:0] x_r [4];
  logic signed [CW-1:0] y_r [4];
  logic signed [CW-1:0] z_r [4];
  qbpc_in_t             it1_r;

  logic signed [KW-1:0] m_r   [9];
  logic signed [KW-1:0] lin_r [3];
  logic signed [CW-1:0] d2_r;
  logic signed [CW-1:0] cf    [6];
  logic signed [63:0]   hi_r  [6];
  logic signed [64:0]   lo_r  [6];
  logic signed [TW-1:0] t_r   [10];
  logic signed [TW-1:0] s_r   [3];
  qbpc_out_t            out_nxt, out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    sv_r <= {sv_r[2:0], solvable};
    x_r[0] <= px;
    y_r[0] <= py;
    z_r[0] <= pz;
    for (int i = 1; i < 4; i++) begin
      x_r[i] <= x_r[i-1];
      y_r[i] <= y_r[i-1];
      z_r[i] <= z_r[i-1];
    end
    it1_r <= item;
  end

  // Stage one: point products and the linear products.
  always_ff @(posedge clk) begin
    m_r[0] <= px * px;
    m_r[1] <= px * py;
    m_r[2] <= px * pz;
    m_r[3] <= py * py;
    m_r[4] <= py * pz;
    m_r[5] <= pz * pz;
    m_r[6] <= px * item.q_xw;
    m_r[7] <= py * item.q_yw;
    m_r[8] <= pz * item.q_zw;
  end

  always_comb begin
    cf[0] = it1_r.q_xx;
    cf[1] = it1_r.q_xy;
    cf[2] = it1_r.q_xz;
    cf[3] = it1_r.q_yy;
    cf[4] = it1_r.q_yz;
    cf[5] = it1_r.q_zz;
  end

  // Stage two: split 64 by 32 products.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      hi_r[i] <= pp_hi(m_r[i], cf[i]);
      lo_r[i] <= pp_lo(m_r[i], cf[i]);
    end
    for (int i = 0; i < 3; i++) begin
      lin_r[i] <= m_r[6+i];
    end
    d2_r <= it1_r.q_ww;
  end

  // Stage three: all terms at the 2^-48 scale. Cross terms count twice.
  always_ff @(posedge clk) begin
    t_r[0] <= pp_join(hi_r[0], lo_r[0]);
    t_r[1] <= pp_join(hi_r[1], lo_r[1]) <<< 1;
    t_r[2] <= pp_join(hi_r[2], lo_r[2]) <<< 1;
    t_r[3] <= pp_join(hi_r[3], lo_r[3]);
    t_r[4] <= pp_join(hi_r[4], lo_r[4]) <<< 1;
    t_r[5] <= pp_join(hi_r[5], lo_r[5]);
    for (int i = 0; i < 3; i++) begin
      t_r[6+i] <= {{(TW-KW){lin_r[i][KW-1]}}, lin_r[i]} <<< 17;
    end
    t_r[9] <= {{(TW-CW){d2_r[CW-1]}}, d2_r} <<< 32;
  end

  always_ff @(posedge clk) begin
    s_r[0] <= t_r[0] + t_r[1] + t_r[2] + t_r[3];
    s_r[1] <= t_r[4] + t_r[5] + t_r[6] + t_r[7];
    s_r[2] <= t_r[8] + t_r[9] + RND;
  end

  always_comb begin
    logic signed [TW-1:0] tot;
    logic signed [TW-33:0] c;
    tot = s_r[0] + s_r[1] + s_r[2];
    c = tot[TW-1:32];
    out_nxt.solvable = sv_r[3];
    if (sv_r[3]) begin
      out_nxt.best_x = x_r[3];
      out_nxt.best_y = y_r[3];
      out_nxt.best_z = z_r[3];
      // Overflow when the bits above the cost field are not a sign extension.
      if (c[TW-33:EW-1] != {(TW-32-EW+1){c[EW-1]}}) begin
        out_nxt.err_cost = c[TW-33] ? COST_MIN : COST_MAX;
      end else begin
        out_nxt.err_cost = c[EW-1:0];
      end
    end else begin
      out_nxt.best_x   = '0;
      out_nxt.best_y   = '0;
      out_nxt.best_z   = '0;
      out_nxt.err_cost = COST_MAX;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = v_r[4];
  assign out_data  = out_r;

endmodule

>>> sv/quadric_best_point_cost.sv
// Top level of the quadric optimal-vertex and cost evaluator.
//
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------
//  input   | start / busy             | in_data  (ten Q16.16 terms)
//  result  | out_valid strobe         | out_data (point, cost, flag)
//  config  | cfg_valid / cfg_ready    | cfg_data (det_threshold)
//
// One beat is accepted per clock while busy is low; each result passes through
// 6 front-end stages, 35 divider stages and 5 cost stages.
// The 32 quotient bits of each coordinate are resolved one per stage.
// Reset is synchronous; busy is high during reset and low from then on.
// Results are shown for one cycle and cannot be held off.
module quadric_best_point_cost import qbpc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  qbpc_in_t        in_data,
  output logic            out_valid,
  output qbpc_out_t       out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CW-1:0]   cfg_data
);

  logic          busy_r;
  logic [CW-1:0] thr_r;

  logic          f_valid;
  qbpc_in_t      f_item;
  qbpc_sol_t     f_sol;

  logic          dl_v_r [DIV_LAT];
  logic          dl_s_r [DIV_LAT];
  qbpc_in_t      dl_i_r [DIV_LAT];

  logic signed [CW-1:0] pt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      thr_r  <= THR_RESET;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  qbpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy_r),
    .in_data   (in_data),
    .thr       (thr_r),
    .out_valid (f_valid),
    .out_item  (f_item),
    .out_sol   (f_sol)
  );

  for (genvar a = 0; a < 3; a++) begin : g_axis
    qbpc_div u_div (
      .clk     (clk),
      .num_mag (f_sol.num_mag[a]),
      .det_mag (f_sol.det_mag),
      .neg     (f_sol.neg[a]),
      .coord   (pt[a])
    );
  end

  // The beat's coefficients and flags ride alongside the dividers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dl_v_r[i] <= 1'b0;
      end
    end else begin
      dl_v_r[0] <= f_valid;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl_v_r[i] <= dl_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dl_s_r[0] <= f_sol.solvable;
    dl_i_r[0] <= f_item;
    for (int i = 1; i < DIV_LAT; i++) begin
      dl_s_r[i] <= dl_s_r[i-1];
      dl_i_r[i] <= dl_i_r[i-1];
    end
  end

  qbpc_cost u_cost (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dl_v_r[DIV_LAT-1]),
    .solvable  (dl_s_r[DIV_LAT-1]),
    .item      (dl_i_r[DIV_LAT-1]),
    .px        (pt[0]),
    .py        (pt[1]),
    .pz        (pt[2]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> sv/qbpc_chk.sv
// Port-level checker for the quadric best-point cost block, with its bind.
module qbpc_chk import qbpc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input qbpc_out_t out_data
);

  // Every result answers a beat taken a fixed number of cycles earlier.
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching input beat");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("input beat produced no result");

  a_unsolved: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.solvable) |->
      (out_data.best_x == '0 && out_data.best_y == '0 && out_data.best_z == '0 &&
       out_data.err_cost == COST_MAX))
    else $error("unsolvable result carries a point or a finite cost");

endmodule

bind quadric_best_point_cost qbpc_chk u_qbpc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

>>> tb/quadric_best_point_cost_checker.sv
// Checker for the quadric best-point cost block: predicts each result and compares it.
`timescale 1ns / 100ps
module quadric_best_point_cost_checker import qbpc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  qbpc_in_t      in_data,
  input  logic          out_valid,
  input  qbpc_out_t     out_data,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [CW-1:0] cfg_data,
  output int            errors,
  output int            pending
);

  typedef logic signed [127:0] wide_t;

  localparam wide_t WCOST_MAX = 128'sh7FFF_FFFF_FFFF;
  localparam wide_t WCOST_MIN = -128'sh8000_0000_0000;

  logic [CW-1:0] threshold;
  qbpc_out_t     vertex_q[$];

  // Rounded coordinate -num * 2^16 / det, ties away from zero, saturated.
  function automatic logic signed [CW-1:0] solve_coord(input wide_t num, input wide_t det);
    logic        negres;
    logic [127:0] an;
    logic [127:0] ad;
    logic [127:0] q;
    negres = (num < 0) == (det < 0);
    an = (num < 0) ? -num : num;
    ad = (det < 0) ? -det : det;
    q = ((an << 17) + ad) / (ad << 1);
    if (negres) begin
      if (q > 128'h8000_0000) return PT_MIN;
      return -q[CW-1:0];
    end
    if (q > 128'h7FFF_FFFF) return PT_MAX;
    return q[CW-1:0];
  endfunction

  function automatic qbpc_out_t best_vertex(input qbpc_in_t i, input logic [CW-1:0] thr);
    wide_t a2, ab, ac, ad, b2, bc, bd, c2, cd, d2;
    wide_t k00, k01, k02, k11, k12, k22, det, mag, lim, x, y, z, sum, c;
    qbpc_out_t r;
    a2 = i.q_xx; ab = i.q_xy; ac = i.q_xz; ad = i.q_xw; b2 = i.q_yy;
    bc = i.q_yz; bd = i.q_yw; c2 = i.q_zz; cd = i.q_zw; d2 = i.q_ww;
    k00 = b2 * c2 - bc * bc; k01 = bc * ac - ab * c2; k02 = ab * bc - ac * b2;
    k11 = c2 * a2 - ac * ac; k12 = ac * ab - a2 * bc; k22 = a2 * b2 - ab * ab;
    det = k00 * a2 + k01 * ab + k02 * ac;
    mag = (det < 0) ? -det : det;
    lim = {64'd0, thr, 32'd0};
    r = '0;
    if (det == 0 || mag < lim) begin
      r.err_cost = COST_MAX;
      return r;
    end
    x = solve_coord(k00 * ad + k01 * bd + k02 * cd, det);
    y = solve_coord(k01 * ad + k11 * bd + k12 * cd, det);
    z = solve_coord(k02 * ad + k12 * bd + k22 * cd, det);
    sum = x * x * a2 + ((x * y * ab) <<< 1) + ((x * z * ac) <<< 1) + ((x * ad) <<< 17)
        + y * y * b2 + ((y * z * bc) <<< 1) + ((y * bd) <<< 17)
        + z * z * c2 + ((z * cd) <<< 17) + (d2 <<< 32) + 128'sh8000_0000;
    c = sum >>> 32;
    if (c > WCOST_MAX) c = WCOST_MAX;
    if (c < WCOST_MIN) c = WCOST_MIN;
    r.solvable = 1'b1;
    r.best_x = x[CW-1:0];
    r.best_y = y[CW-1:0];
    r.best_z = z[CW-1:0];
    r.err_cost = c[EW-1:0];
    return r;
  endfunction

  assign pending = vertex_q.size();

  always @(posedge clk) begin
    qbpc_out_t want;
    if (!rst_n) begin
      threshold <= THR_RESET;
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) threshold <= cfg_data;
      if (start && !busy) vertex_q = {vertex_q, best_vertex(in_data, threshold)};
      if (out_valid) begin
        if (vertex_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result beat: %p", out_data);
        end else begin
          want = vertex_q.pop_front();
          if (want !== out_data) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: solvable %b/%b x %h/%h y %h/%h z %h/%h cost %h/%h",
                       want.solvable, out_data.solvable, want.best_x, out_data.best_x,
                       want.best_y, out_data.best_y, want.best_z, out_data.best_z,
                       want.err_cost, out_data.err_cost);
          end
        end
      end
    end
  end

endmodule

>>> tb/quadric_best_point_cost_tb.sv
// Testbench top for the quadric best-point cost block: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module quadric_best_point_cost_tb;
  import qbpc_pkg::*;

  localparam int WATCHDOG = 5000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  qbpc_in_t      in_data = '0;
  logic          out_valid;
  qbpc_out_t     out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [CW-1:0] cfg_data = '0;
  int            errors;
  int            pending;
  int            quiet = 0;

  always #2 clk = ~clk;

  quadric_best_point_cost DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  quadric_best_point_cost_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic signed [CW-1:0] rnd_bits(input int nbits);
    logic signed [CW-1:0] v;
    v = $urandom;
    return v >>> (CW - nbits);
  endfunction

  // Sum of plane products gives a well-formed quadric that is usually solvable.
  function automatic qbpc_in_t plane_quadric(input int nplanes);
    qbpc_in_t q;
    logic signed [63:0] a, b, c, d;
    q = '0;
    for (int k = 0; k < nplanes; k++) begin
      a = rnd_bits(17); b = rnd_bits(17); c = rnd_bits(17); d = rnd_bits(24);
      q.q_xx += CW'((a * a) >>> 16); q.q_xy += CW'((a * b) >>> 16);
      q.q_xz += CW'((a * c) >>> 16); q.q_xw += CW'((a * d) >>> 16);
      q.q_yy += CW'((b * b) >>> 16); q.q_yz += CW'((b * c) >>> 16);
      q.q_yw += CW'((b * d) >>> 16); q.q_zz += CW'((c * c) >>> 16);
      q.q_zw += CW'((c * d) >>> 16); q.q_ww += CW'((d * d) >>> 16);
    end
    return q;
  endfunction

  function automatic qbpc_in_t random_quadric();
    qbpc_in_t q;
    int kind, nb;
    kind = $urandom_range(99);
    if (kind < 55) return plane_quadric($urandom_range(8, 3));
    if (kind < 65) return plane_quadric($urandom_range(2, 1));
    nb = (kind < 85) ? 32 : $urandom_range(24, 4);
    q = {rnd_bits(nb), rnd_bits(nb), rnd_bits(nb), rnd_bits(nb), rnd_bits(nb),
         rnd_bits(nb), rnd_bits(nb), rnd_bits(nb), rnd_bits(nb), rnd_bits(nb)};
    return q;
  endfunction

  task automatic send_beat(input qbpc_in_t item, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [CW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CW-1:0] thr_set[6];
    int idle_set[4];
    localparam logic signed [CW-1:0] ONE = 32'sh1_0000;
    thr_set = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0100, 32'd0};
    idle_set = '{0, 86, 35, 0};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero tensor, identity, exact ties, extremes and near-singular cases.
    send_beat('0, 0);
    send_beat('{ONE, 0, 0, ONE, ONE, 0, -ONE, ONE, 32'sh8000, ONE}, 0);
    send_beat('{ONE, 0, 0, 32'sh1, ONE, 0, -32'sh1, ONE, 0, 0}, 0);
    send_beat('{2 * ONE, 0, 0, 32'sh1, 2 * ONE, 0, 32'sh3, 2 * ONE, -32'sh1, 0}, 0);
    send_beat({10{PT_MAX}}, 0);
    send_beat({10{PT_MIN}}, 0);
    send_beat('{PT_MAX, 0, 0, PT_MIN, PT_MAX, 0, PT_MAX, PT_MAX, PT_MIN, PT_MIN}, 0);
    send_beat('{PT_MIN, 0, 0, PT_MAX, PT_MIN, 0, PT_MIN, PT_MIN, PT_MAX, PT_MAX}, 0);
    send_beat('{32'sh1, 0, 0, PT_MAX, 32'sh1, 0, PT_MIN, 32'sh1, PT_MAX, PT_MAX}, 0);
    send_beat('{ONE, ONE, 0, ONE, ONE, 0, ONE, ONE, ONE, ONE}, 0);
    send_beat('{32'sh10, 0, 0, 0, 32'sh10, 0, 0, 32'sh10, 0, 0}, 0);
    send_beat('{32'sh100, 0, 0, 0, 32'sh100, 0, 0, 32'sh100, 0, 0}, 0);
    send_beat('{ONE, 0, 0, 32'sh7FFF_0000, ONE, 0, 0, ONE, 0, PT_MAX}, 0);
    send_beat('{-ONE, 0, 0, ONE, -ONE, 0, ONE, -ONE, ONE, PT_MIN}, 0);
    send_beat(plane_quadric(2), 0);
    send_beat(plane_quadric(3), 0);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_threshold(ph == 5 ? $urandom : thr_set[ph]);
      for (int n = 0; n < 340; n++) begin
        send_beat(random_quadric(), idle_set[ph % 4]);
        if (n == 170 && ph == 2) begin
          start <= 1'b0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
        end
      end
    end
    drain();

    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/qbpc_pkg.sv
sv/qbpc_front.sv
sv/qbpc_div.sv
sv/qbpc_cost.sv
sv/quadric_best_point_cost.sv
sv/qbpc_chk.sv
tb/quadric_best_point_cost_checker.sv
tb/quadric_best_point_cost_tb.sv
